[hdl/hmbs_pkg.sv]
// Shared constants, codes and types of the heightmap bilinear sampler.
package hmbs_pkg;

	localparam int MEM_AW        = 16;
	localparam int HEIGHT_W      = 8;
	localparam int DIM_W         = 9;
	localparam int COORD_W       = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;
	localparam int NORM_BITS     = 40;
	localparam int MAX_DIM_DEF   = 256;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SIZE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd3;

	typedef struct packed {
		logic                we;
		logic [MEM_AW-1:0]   addr;
		logic [HEIGHT_W-1:0] data;
	} hmbs_wr_t;

endpackage

[hdl/hmbs_req_if.sv]
// Request channel: height entry writes and sample beats.
interface hmbs_req_if;
	import hmbs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [MEM_AW-1:0]         entry_index;
	logic [HEIGHT_W-1:0]       height_value;
	logic signed [COORD_W-1:0] world_x;
	logic signed [COORD_W-1:0] world_z;

	modport source (output valid, cmd, entry_index, height_value, world_x, world_z,
		input ready);
	modport sink (input valid, cmd, entry_index, height_value, world_x, world_z,
		output ready);
endinterface

[hdl/hmbs_rsp_if.sv]
// Result channel: interpolated height beats.
interface hmbs_rsp_if;
	import hmbs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] height;

	modport source (output valid, height, input ready);
	modport sink (input valid, height, output ready);
endinterface

[hdl/hmbs_cfg_if.sv]
// Configuration write channel: register index and data.
interface hmbs_cfg_if;
	import hmbs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/hmbs_ram.sv]
// One copy of the height memory: one write port, one registered read port.
module hmbs_ram (
	input  logic                             clk,
	input  logic                             rd_en,
	input  hmbs_pkg::hmbs_wr_t               wr,
	input  logic [hmbs_pkg::MEM_AW-1:0]      raddr,
	output logic [hmbs_pkg::HEIGHT_W-1:0]    rdata
);
	import hmbs_pkg::*;

	localparam int DEPTH = 1 << MEM_AW;

	logic [HEIGHT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[hdl/heightmap_bilinear_sampler.sv]
// Top level of the heightmap bilinear sampler: eight-stage sample pipeline.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   cmd, entry_index, height_value, world_x, world_z
//  rsp      out  valid/ready   height
//  cfg      in   valid/ready   index, data (ready always high)
//
// One beat per cycle on req, unless back-pressure on rsp holds the pipeline.
// Four copies of the height memory, each read at one address per cycle, give the
// four neighbours at once; an entry write updates all copies in pipeline order.
// Reset clears valid bits and config (size 256); memory is undefined until written.
// A stage holds only when the stage after it is full and held, so bubbles close up.
module heightmap_bilinear_sampler #(
	parameter int FRAC_BITS = hmbs_pkg::FRAC_BITS_DEF,
	parameter int MAX_DIM   = hmbs_pkg::MAX_DIM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hmbs_req_if.sink   req,
	hmbs_rsp_if.source rsp,
	hmbs_cfg_if.sink   cfg
);
	import hmbs_pkg::*;

	localparam int PX_W   = 2 * COORD_W - 1;
	localparam int POS_W  = NORM_BITS + DIM_W;
	localparam int TOP_W  = FRAC_BITS + 8;
	localparam int BLD_W  = 2 * FRAC_BITS + 8;
	localparam int B16_W  = 24;
	localparam int PROD_W = B16_W + COORD_W;
	localparam int PS_W   = PROD_W - 16;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [DIM_W-1:0]      map_width_q;
	logic [DIM_W-1:0]      map_height_q;
	logic [COORD_W-1:0]    inv_size_q;
	logic [COORD_W-1:0]    height_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q    <= DIM_W'(256);
			map_height_q   <= DIM_W'(256);
			inv_size_q     <= '0;
			height_scale_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAP_WIDTH:    map_width_q    <= cfg.data[DIM_W-1:0];
				REG_MAP_HEIGHT:   map_height_q   <= cfg.data[DIM_W-1:0];
				REG_INV_SIZE:     inv_size_q     <= cfg.data;
				REG_HEIGHT_SCALE: height_scale_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	logic [DIM_W-1:0] w_eff, h_eff, wm1, hm1;

	always_comb begin
		if (map_width_q < DIM_W'(2)) begin
			w_eff = DIM_W'(2);
		end else if (32'(map_width_q) > 32'(MAX_DIM)) begin
			w_eff = DIM_W'(MAX_DIM);
		end else begin
			w_eff = map_width_q;
		end
		if (map_height_q < DIM_W'(2)) begin
			h_eff = DIM_W'(2);
		end else if (32'(map_height_q) > 32'(MAX_DIM)) begin
			h_eff = DIM_W'(MAX_DIM);
		end else begin
			h_eff = map_height_q;
		end
		wm1 = w_eff - DIM_W'(1);
		hm1 = h_eff - DIM_W'(1);
	end

	// stage advance and valid bits
	logic [8:1] en;
	logic [7:1] vld_q;
	logic       out_vld_q;

	always_comb begin
		en[8] = !out_vld_q || rsp.ready;
		for (int k = 7; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign req.ready = en[1];

	// pipeline payload
	logic                 cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6, cmd_s7;
	logic [MEM_AW-1:0]    eidx_s1, eidx_s2, eidx_s3;
	logic [HEIGHT_W-1:0]  hval_s1, hval_s2, hval_s3;
	logic [PX_W-1:0]      px_s1, pz_s1;
	logic                 negx_s1, negz_s1;
	logic [DIM_W-1:0]     x0_s2, z0_s2;
	logic [FRAC_BITS-1:0] fx_s2, fz_s2, fx_s3, fz_s3, fx_s4, fz_s4, fz_s5;
	logic [MEM_AW-1:0]    addr_s3 [4];
	logic [HEIGHT_W-1:0]  hgt_s4 [4];
	logic [TOP_W-1:0]     top_s5, bot_s5;
	logic [B16_W-1:0]     b16_s6;
	logic [PS_W-1:0]      prod_s7;
	logic                 neg_s7;
	logic signed [COORD_W-1:0] height_q;

	// stage 1: coordinate times reciprocal
	logic [PX_W-1:0] px_c, pz_c;
	assign px_c = PX_W'(req.world_x[COORD_W-2:0]) * PX_W'(inv_size_q);
	assign pz_c = PX_W'(req.world_z[COORD_W-2:0]) * PX_W'(inv_size_q);

	// stage 2: clamp and scale by dimension minus one
	logic [POS_W-1:0]     posx_c, posz_c;
	logic [DIM_W-1:0]     x0_c, z0_c;
	logic [FRAC_BITS-1:0] fx_c, fz_c;

	always_comb begin
		posx_c = POS_W'(px_s1[NORM_BITS-1:0]) * POS_W'(wm1);
		posz_c = POS_W'(pz_s1[NORM_BITS-1:0]) * POS_W'(hm1);
		if (negx_s1) begin
			x0_c = '0;
			fx_c = '0;
		end else if (|px_s1[PX_W-1:NORM_BITS]) begin
			x0_c = wm1;
			fx_c = '0;
		end else begin
			x0_c = posx_c[POS_W-1:NORM_BITS];
			fx_c = posx_c[NORM_BITS-1:NORM_BITS-FRAC_BITS];
		end
		if (negz_s1) begin
			z0_c = '0;
			fz_c = '0;
		end else if (|pz_s1[PX_W-1:NORM_BITS]) begin
			z0_c = hm1;
			fz_c = '0;
		end else begin
			z0_c = posz_c[POS_W-1:NORM_BITS];
			fz_c = posz_c[NORM_BITS-1:NORM_BITS-FRAC_BITS];
		end
	end

	// stage 3: neighbour indices and addresses
	logic [DIM_W-1:0]     x1_c, z1_c;
	logic [2*DIM_W-1:0]   row0_c, row1_c;

	always_comb begin
		x1_c = ((DIM_W+1)'(x0_s2) + (DIM_W+1)'(1) < (DIM_W+1)'(w_eff))
			? x0_s2 + DIM_W'(1) : wm1;
		z1_c = ((DIM_W+1)'(z0_s2) + (DIM_W+1)'(1) < (DIM_W+1)'(h_eff))
			? z0_s2 + DIM_W'(1) : hm1;
		row0_c = (2*DIM_W)'(z0_s2) * (2*DIM_W)'(w_eff);
		row1_c = (2*DIM_W)'(z1_c) * (2*DIM_W)'(w_eff);
	end

	// stage 4: memory copies
	hmbs_wr_t wr;
	assign wr.we   = en[4] && vld_q[3] && (cmd_s3 == CMD_WRITE);
	assign wr.addr = eidx_s3;
	assign wr.data = hval_s3;

	for (genvar g = 0; g < 4; g++) begin : g_bank
		hmbs_ram u_ram (
			.clk   (clk),
			.rd_en (en[4]),
			.wr    (wr),
			.raddr (addr_s3[g]),
			.rdata (hgt_s4[g])
		);
	end

	// stage 5: horizontal blend
	logic [FRAC_BITS:0]   omfx_c, omfz_c;
	logic [TOP_W:0]       top_c, bot_c;

	always_comb begin
		omfx_c = ONE - (FRAC_BITS+1)'(fx_s4);
		top_c  = (TOP_W+1)'(hgt_s4[0]) * (TOP_W+1)'(omfx_c)
			+ (TOP_W+1)'(hgt_s4[1]) * (TOP_W+1)'(fx_s4);
		bot_c  = (TOP_W+1)'(hgt_s4[2]) * (TOP_W+1)'(omfx_c)
			+ (TOP_W+1)'(hgt_s4[3]) * (TOP_W+1)'(fx_s4);
	end

	// stage 6: vertical blend
	logic [BLD_W:0] blend_c;

	always_comb begin
		omfz_c  = ONE - (FRAC_BITS+1)'(fz_s5);
		blend_c = (BLD_W+1)'(top_s5) * (BLD_W+1)'(omfz_c)
			+ (BLD_W+1)'(bot_s5) * (BLD_W+1)'(fz_s5);
	end

	// stage 7: gain
	logic                neg_c;
	logic [COORD_W-1:0]  mag_c;
	logic [PROD_W-1:0]   prod_c;

	always_comb begin
		neg_c  = height_scale_q[COORD_W-1];
		mag_c  = neg_c ? (~height_scale_q + COORD_W'(1)) : height_scale_q;
		prod_c = PROD_W'(b16_s6) * PROD_W'(mag_c);
	end

	// stage 8: saturate
	logic [COORD_W-1:0] sat_c;

	always_comb begin
		if (inv_size_q == '0) begin
			sat_c = '0;
		end else if (neg_s7) begin
			sat_c = (|prod_s7[PS_W-1:COORD_W-1]) ? {1'b1, {(COORD_W-1){1'b0}}}
				: COORD_W'(0) - prod_s7[COORD_W-1:0];
		end else begin
			sat_c = (|prod_s7[PS_W-1:COORD_W-1]) ? {1'b0, {(COORD_W-1){1'b1}}}
				: prod_s7[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= req.valid;
			end
			for (int k = 2; k <= 7; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (en[8]) begin
				out_vld_q <= vld_q[7] && (cmd_s7 == CMD_SAMPLE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cmd_s1  <= req.cmd;
			eidx_s1 <= req.entry_index;
			hval_s1 <= req.height_value;
			px_s1   <= px_c;
			pz_s1   <= pz_c;
			negx_s1 <= req.world_x[COORD_W-1];
			negz_s1 <= req.world_z[COORD_W-1];
		end
		if (en[2]) begin
			cmd_s2  <= cmd_s1;
			eidx_s2 <= eidx_s1;
			hval_s2 <= hval_s1;
			x0_s2   <= x0_c;
			z0_s2   <= z0_c;
			fx_s2   <= fx_c;
			fz_s2   <= fz_c;
		end
		if (en[3]) begin
			cmd_s3     <= cmd_s2;
			eidx_s3    <= eidx_s2;
			hval_s3    <= hval_s2;
			fx_s3      <= fx_s2;
			fz_s3      <= fz_s2;
			addr_s3[0] <= MEM_AW'(row0_c + (2*DIM_W)'(x0_s2));
			addr_s3[1] <= MEM_AW'(row0_c + (2*DIM_W)'(x1_c));
			addr_s3[2] <= MEM_AW'(row1_c + (2*DIM_W)'(x0_s2));
			addr_s3[3] <= MEM_AW'(row1_c + (2*DIM_W)'(x1_c));
		end
		if (en[4]) begin
			cmd_s4 <= cmd_s3;
			fx_s4  <= fx_s3;
			fz_s4  <= fz_s3;
		end
		if (en[5]) begin
			cmd_s5 <= cmd_s4;
			fz_s5  <= fz_s4;
			top_s5 <= top_c[TOP_W-1:0];
			bot_s5 <= bot_c[TOP_W-1:0];
		end
		if (en[6]) begin
			cmd_s6 <= cmd_s5;
			b16_s6 <= blend_c[BLD_W-1:BLD_W-B16_W];
		end
		if (en[7]) begin
			cmd_s7  <= cmd_s6;
			neg_s7  <= neg_c;
			prod_s7 <= prod_c[PROD_W-1:16];
		end
		if (en[8]) begin
			height_q <= sat_c;
		end
	end

	assign rsp.valid  = out_vld_q;
	assign rsp.height = height_q;
endmodule
